// ----- rtl/gehc_pkg.sv -----
// shared constants, types and the arctangent table of the edge colorizer
`timescale 1ns / 1ps
package gehc_pkg;

    // magnitude fraction bits and rotation count of the angle unit
    localparam int MAG_FRAC_BITS = 8;
    localparam int CORDIC_STEPS  = 16;

    // magnitude and square root widths
    localparam int MAG_W  = 17;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;
    localparam int SQ_W   = 17;
    localparam int RAD_W  = 2 * ((SQ_W + 2 * MAG_FRAC_BITS + 1) / 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int QUO_W  = 16;
    localparam int RES_W  = (ROOT_W > QUO_W) ? ROOT_W : QUO_W;
    localparam int SUB_W  = (ROOT_W + 3 > MAG_W + 2) ? ROOT_W + 3 : MAG_W + 2;
    localparam int RD_CNT_W = $clog2(RES_W);

    // normalized value and threshold
    localparam int V_W = 17;
    localparam logic [V_W-1:0] V_ONE = 17'h10000;
    localparam int THR_W = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd5898;

    // angle in degrees Q.16
    localparam int ANG_W = 23;
    localparam logic [ANG_W-1:0] ANGLE_60 = 23'd3932160;
    localparam logic [ANG_W-1:0] ANGLE_90 = 23'd5898240;
    localparam int CD_W = 28;
    localparam int Z_W  = 26;
    localparam int CD_CNT_W = $clog2(CORDIC_STEPS);

    // operation codes
    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_MEASURE = 2'd1,
        OP_MAP     = 2'd2
    } op_t;

    // command to the root and divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } rd_cmd_t;

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // atan(2^-i) in degrees Q.16, rounded to nearest
    function automatic logic [Z_W-1:0] atan_entry(input logic [4:0] idx);
        logic [Z_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = Z_W'(2949120);
                5'd1:    val = Z_W'(1740967);
                5'd2:    val = Z_W'(919879);
                5'd3:    val = Z_W'(466945);
                5'd4:    val = Z_W'(234379);
                5'd5:    val = Z_W'(117305);
                5'd6:    val = Z_W'(58666);
                5'd7:    val = Z_W'(29335);
                5'd8:    val = Z_W'(14668);
                5'd9:    val = Z_W'(7334);
                5'd10:   val = Z_W'(3667);
                5'd11:   val = Z_W'(1833);
                5'd12:   val = Z_W'(917);
                5'd13:   val = Z_W'(458);
                5'd14:   val = Z_W'(229);
                5'd15:   val = Z_W'(115);
                5'd16:   val = Z_W'(57);
                5'd17:   val = Z_W'(29);
                5'd18:   val = Z_W'(14);
                5'd19:   val = Z_W'(7);
                5'd20:   val = Z_W'(4);
                5'd21:   val = Z_W'(2);
                5'd22:   val = Z_W'(1);
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

// ----- rtl/gehc_rootdiv.sv -----
// shared subtract-compare unit: digit-serial square root and restoring divide
`timescale 1ns / 1ps
module gehc_rootdiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gehc_pkg::rd_cmd_t           cmd,
    input  logic [7:0]                  gx,
    input  logic [7:0]                  gy,
    input  logic [gehc_pkg::MAG_W-1:0]  num,
    input  logic [gehc_pkg::MAG_W-1:0]  den,
    output gehc_pkg::unit_stat_t        stat,
    output logic [gehc_pkg::MAG_W-1:0]  mag,
    output logic [gehc_pkg::QUO_W-1:0]  quo
);

    localparam int WIDE_W = gehc_pkg::ROOT_W + gehc_pkg::MAG_W;

    logic                             busy_reg;
    logic                             done_reg;
    logic                             div_reg;
    logic [gehc_pkg::RD_CNT_W-1:0]    cnt_reg;
    logic [gehc_pkg::SUB_W-1:0]       rem_reg;
    logic [gehc_pkg::RAD_W-1:0]       rad_reg;
    logic [gehc_pkg::RES_W-1:0]       res_reg;
    logic [gehc_pkg::MAG_W-1:0]       den_reg;

    logic [15:0]                      gx2;
    logic [15:0]                      gy2;
    logic [gehc_pkg::SQ_W-1:0]        sq;
    logic [gehc_pkg::SUB_W-1:0]       op_a;
    logic [gehc_pkg::SUB_W-1:0]       op_b;
    logic [gehc_pkg::SUB_W:0]         diff;
    logic                             ge;
    logic [WIDE_W-1:0]                root_wide;

    // sum of squares of the gradient bytes
    assign gx2 = 16'(gx) * 16'(gx);
    assign gy2 = 16'(gy) * 16'(gy);
    assign sq  = gehc_pkg::SQ_W'(gx2) + gehc_pkg::SQ_W'(gy2);

    // operand select and the shared subtractor
    always_comb
    begin
        if (div_reg)
        begin
            op_a = {rem_reg[gehc_pkg::SUB_W-2:0], 1'b0};
            op_b = gehc_pkg::SUB_W'(den_reg);
        end
        else
        begin
            op_a = {rem_reg[gehc_pkg::SUB_W-3:0], rad_reg[gehc_pkg::RAD_W-1 -: 2]};
            op_b = gehc_pkg::SUB_W'({res_reg[gehc_pkg::ROOT_W-1:0], 2'b01});
        end
        diff = {1'b0, op_a} - {1'b0, op_b};
        ge   = !diff[gehc_pkg::SUB_W];
    end

    // iteration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            rad_reg  <= '0;
            res_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                div_reg  <= cmd.is_div;
                res_reg  <= '0;
                den_reg  <= den;
                rad_reg  <= gehc_pkg::RAD_W'(sq) << (2 * gehc_pkg::MAG_FRAC_BITS);
                if (cmd.is_div)
                begin
                    cnt_reg <= gehc_pkg::RD_CNT_W'(gehc_pkg::QUO_W - 1);
                    rem_reg <= gehc_pkg::SUB_W'(num);
                end
                else
                begin
                    cnt_reg <= gehc_pkg::RD_CNT_W'(gehc_pkg::ROOT_W - 1);
                    rem_reg <= '0;
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[gehc_pkg::SUB_W-1:0] : op_a;
                res_reg <= {res_reg[gehc_pkg::RES_W-2:0], ge};
                rad_reg <= rad_reg << 2;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // saturated root and quotient
    assign root_wide = WIDE_W'(res_reg[gehc_pkg::ROOT_W-1:0]);
    assign mag = (root_wide > WIDE_W'(gehc_pkg::MAG_MAX)) ? gehc_pkg::MAG_MAX
                                                          : root_wide[gehc_pkg::MAG_W-1:0];
    assign quo = res_reg[gehc_pkg::QUO_W-1:0];

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- rtl/gehc_cordic.sv -----
// vectoring rotation unit: gradient angle, one micro-rotation per cycle
`timescale 1ns / 1ps
module gehc_cordic (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [7:0]                  gx,
    input  logic [7:0]                  gy,
    output logic                        busy,
    output logic [gehc_pkg::ANG_W-1:0]  angle
);

    logic                              busy_reg;
    logic [gehc_pkg::CD_CNT_W-1:0]     cnt_reg;
    logic signed [gehc_pkg::CD_W-1:0]  x_reg;
    logic signed [gehc_pkg::CD_W-1:0]  y_reg;
    logic [gehc_pkg::Z_W-1:0]          z_reg;
    logic [gehc_pkg::ANG_W-1:0]        angle_reg;

    logic signed [gehc_pkg::CD_W-1:0]  xs;
    logic signed [gehc_pkg::CD_W-1:0]  ys;
    logic                              y_pos;
    logic [gehc_pkg::Z_W-1:0]          step;
    logic signed [gehc_pkg::CD_W-1:0]  x_next;
    logic signed [gehc_pkg::CD_W-1:0]  y_next;
    logic [gehc_pkg::Z_W-1:0]          z_next;
    logic [gehc_pkg::ANG_W-1:0]        z_clamped;

    // one micro-rotation
    always_comb
    begin
        xs    = x_reg >>> cnt_reg;
        ys    = y_reg >>> cnt_reg;
        y_pos = !y_reg[gehc_pkg::CD_W-1] && (y_reg != '0);
        step  = gehc_pkg::atan_entry(5'(cnt_reg));
        if (y_pos)
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + step;
        end
        else
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - step;
        end
        // clamp to the first quadrant
        if (z_next[gehc_pkg::Z_W-1])
            z_clamped = '0;
        else if (z_next > gehc_pkg::Z_W'(gehc_pkg::ANGLE_90))
            z_clamped = gehc_pkg::ANGLE_90;
        else
            z_clamped = z_next[gehc_pkg::ANG_W-1:0];
    end

    // rotation registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            angle_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= '0;
            z_reg   <= '0;
            x_reg   <= gehc_pkg::CD_W'({gx, 16'h0000});
            y_reg   <= gehc_pkg::CD_W'({gy, 16'h0000});
            // axis cases resolve at once
            if (gy == 8'd0)
                angle_reg <= '0;
            else if (gx == 8'd0)
                angle_reg <= gehc_pkg::ANGLE_90;
            else
                busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == gehc_pkg::CD_CNT_W'(gehc_pkg::CORDIC_STEPS - 1))
            begin
                busy_reg  <= 1'b0;
                angle_reg <= z_clamped;
            end
        end
    end

    assign busy  = busy_reg;
    assign angle = angle_reg;

endmodule

// ----- rtl/gehc_color.sv -----
// hsl to rgb mapping on one shared multiplier under a short sequencer
`timescale 1ns / 1ps
module gehc_color (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gehc_pkg::V_W-1:0]    vq,
    input  logic [gehc_pkg::ANG_W-1:0]  angle,
    output gehc_pkg::unit_stat_t        stat,
    output logic [7:0]                  red,
    output logic [7:0]                  green,
    output logic [7:0]                  blue,
    output logic [7:0]                  edge_strength
);

    typedef enum logic [2:0] {
        C_IDLE,
        C_MUL1,
        C_MUL2,
        C_FIN1,
        C_FIN2,
        C_FIN3
    } col_state_t;

    col_state_t                  state_reg;
    logic                        done_reg;
    logic [gehc_pkg::V_W-1:0]    vq_reg;
    logic                        low_hue_reg;
    logic [21:0]                 w_reg;
    logic [31:0]                 c32_reg;
    logic [53:0]                 p_reg;
    logic [34:0]                 s_reg;
    logic [33:0]                 t_reg;
    logic [37:0]                 t15_reg;
    logic [56:0]                 u_reg;
    logic [7:0]                  zb_reg;
    logic [7:0]                  red_reg;
    logic [7:0]                  green_reg;
    logic [7:0]                  blue_reg;
    logic [7:0]                  edge_reg;

    logic [17:0]                 twice;
    logic [17:0]                 dev;
    logic [17:0]                 a_fac;
    logic [31:0]                 mul_a;
    logic [21:0]                 mul_b;
    logic [53:0]                 prod;
    logic [gehc_pkg::V_W+7:0]    v255;
    logic                        low_hue;
    logic [21:0]                 w;
    logic [42:0]                 s255;
    logic [41:0]                 t255;
    logic [61:0]                 u17;
    logic [7:0]                  xb;

    // chroma factor (1 - |2v - 1|) and hue weight |h - 240|
    always_comb
    begin
        twice   = {vq_reg, 1'b0};
        dev     = (twice >= 18'h10000) ? twice - 18'h10000 : 18'h10000 - twice;
        a_fac   = 18'h10000 - dev;
        low_hue = angle < gehc_pkg::ANGLE_60;
        w       = low_hue ? 22'(gehc_pkg::ANGLE_60 - angle)
                          : 22'(angle - gehc_pkg::ANGLE_60);
        v255    = {vq, 8'h00} - (gehc_pkg::V_W + 8)'(vq);
    end

    // shared multiplier
    always_comb
    begin
        if (state_reg == C_MUL1)
        begin
            mul_a = 32'(a_fac);
            mul_b = 22'(vq_reg);
        end
        else
        begin
            mul_a = c32_reg;
            mul_b = w_reg;
        end
        prod = 54'(mul_a) * 54'(mul_b);
    end

    // final scaling by 255 and by 17 as shift-add
    always_comb
    begin
        s255 = {s_reg, 8'h00} - 43'(s_reg);
        t255 = {t_reg, 8'h00} - 42'(t_reg);
        u17  = 62'({u_reg, 4'h0}) + 62'(u_reg);
        xb   = u17[58:51];
    end

    // sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= C_IDLE;
            done_reg    <= 1'b0;
            vq_reg      <= '0;
            low_hue_reg <= 1'b0;
            w_reg       <= '0;
            c32_reg     <= '0;
            p_reg       <= '0;
            s_reg       <= '0;
            t_reg       <= '0;
            t15_reg     <= '0;
            u_reg       <= '0;
            zb_reg      <= '0;
            red_reg     <= '0;
            green_reg   <= '0;
            blue_reg    <= '0;
            edge_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        vq_reg      <= vq;
                        low_hue_reg <= low_hue;
                        w_reg       <= w;
                        edge_reg    <= v255[23:16];
                        state_reg   <= C_MUL1;
                    end
                end
                C_MUL1:
                begin
                    c32_reg   <= prod[31:0];
                    state_reg <= C_MUL2;
                end
                C_MUL2:
                begin
                    p_reg     <= prod;
                    s_reg     <= 35'({vq_reg, 17'h00000}) + 35'(c32_reg);
                    t_reg     <= {vq_reg, 17'h00000} - 34'(c32_reg);
                    state_reg <= C_FIN1;
                end
                C_FIN1:
                begin
                    t15_reg   <= {t_reg, 4'h0} - 38'(t_reg);
                    blue_reg  <= s255[40:33];
                    zb_reg    <= t255[40:33];
                    state_reg <= C_FIN2;
                end
                C_FIN2:
                begin
                    u_reg     <= 57'({p_reg, 1'b0}) + 57'({t15_reg, 18'h00000});
                    state_reg <= C_FIN3;
                end
                C_FIN3:
                begin
                    red_reg   <= low_hue_reg ? zb_reg : xb;
                    green_reg <= low_hue_reg ? xb : zb_reg;
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign stat.busy     = (state_reg != C_IDLE);
    assign stat.done     = done_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign edge_strength = edge_reg;

endmodule

// ----- rtl/gradient_edge_hsl_colorize.sv -----
// top level of the two-pass gradient edge colorizer
//
//  channel   direction  signals                                  handshake
//  input     in         operation, grad_x, grad_y                in_valid / in_ready
//  result    out        red, green, blue, edge_strength          out_valid / out_ready
//  config    in         cfg_wr_data (edge threshold)             cfg_wr_en, no wait
//
// a clear transaction resets the extremes while the sequencer stays idle; a measure
// transaction runs the 17 digit steps of the square root on the shared subtractor.
// a map transaction runs the root, then a 16-step divide on the
// same subtractor, then the shared multiplier; the angle rotations
// run alongside the root. rst_n clears the extremes and loads the threshold.
// a waiting result does not block a new transaction until the next one is done.
`timescale 1ns / 1ps
module gradient_edge_hsl_colorize (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  grad_x,
    input  logic [7:0]  grad_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  edge_strength,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_DIV,
        S_THR,
        S_COLOR,
        S_OUT
    } state_t;

    state_t                          state_reg, state_next;
    logic                            map_reg, map_next;
    logic [gehc_pkg::MAG_W-1:0]      min_reg, min_next;
    logic [gehc_pkg::MAG_W-1:0]      max_reg, max_next;
    logic [gehc_pkg::THR_W-1:0]      thr_reg, thr_next;
    logic [gehc_pkg::V_W-1:0]        vq_reg, vq_next;
    logic                            out_valid_reg, out_valid_next;
    logic [7:0]                      red_reg, red_next;
    logic [7:0]                      green_reg, green_next;
    logic [7:0]                      blue_reg, blue_next;
    logic [7:0]                      edge_reg, edge_next;

    gehc_pkg::rd_cmd_t               rd_cmd;
    gehc_pkg::unit_stat_t            rd_stat;
    logic [gehc_pkg::MAG_W-1:0]      rd_num;
    logic [gehc_pkg::MAG_W-1:0]      rd_den;
    logic [gehc_pkg::MAG_W-1:0]      rd_mag;
    logic [gehc_pkg::QUO_W-1:0]      rd_quo;
    logic                            cd_start;
    logic                            cd_busy;
    logic [gehc_pkg::ANG_W-1:0]      cd_angle;
    logic                            col_start;
    gehc_pkg::unit_stat_t            col_stat;
    logic [gehc_pkg::V_W-1:0]        col_vq;
    logic [7:0]                      col_red;
    logic [7:0]                      col_green;
    logic [7:0]                      col_blue;
    logic [7:0]                      col_edge;

    gehc_rootdiv u_rootdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rd_cmd),
        .gx    (grad_x),
        .gy    (grad_y),
        .num   (rd_num),
        .den   (rd_den),
        .stat  (rd_stat),
        .mag   (rd_mag),
        .quo   (rd_quo)
    );

    gehc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .gx    (grad_x),
        .gy    (grad_y),
        .busy  (cd_busy),
        .angle (cd_angle)
    );

    gehc_color u_color (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (col_start),
        .vq            (col_vq),
        .angle         (cd_angle),
        .stat          (col_stat),
        .red           (col_red),
        .green         (col_green),
        .blue          (col_blue),
        .edge_strength (col_edge)
    );

    // divide operands and thresholded value
    assign rd_num = rd_mag - min_reg;
    assign rd_den = max_reg - min_reg;
    assign col_vq = (vq_reg <= gehc_pkg::V_W'(thr_reg)) ? '0 : vq_reg;
    assign in_ready = (state_reg == S_IDLE);

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        map_next       = map_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        vq_next        = vq_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        edge_next      = edge_reg;
        out_valid_next = out_valid_reg && !out_ready;
        thr_next       = cfg_wr_en ? cfg_wr_data : thr_reg;
        rd_cmd         = '0;
        cd_start       = 1'b0;
        col_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (operation)
                        gehc_pkg::OP_CLEAR:
                        begin
                            min_next = gehc_pkg::MAG_MAX;
                            max_next = '0;
                        end
                        gehc_pkg::OP_MEASURE:
                        begin
                            rd_cmd.start = 1'b1;
                            map_next     = 1'b0;
                            state_next   = S_ROOT;
                        end
                        gehc_pkg::OP_MAP:
                        begin
                            rd_cmd.start = 1'b1;
                            cd_start     = 1'b1;
                            map_next     = 1'b1;
                            state_next   = S_ROOT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ROOT:
            begin
                if (rd_stat.done)
                begin
                    if (!map_reg)
                    begin
                        // measuring pass: track extremes
                        if (rd_mag < min_reg)
                            min_next = rd_mag;
                        if (rd_mag > max_reg)
                            max_next = rd_mag;
                        state_next = S_IDLE;
                    end
                    else if ((max_reg <= min_reg) || (rd_mag <= min_reg))
                    begin
                        vq_next    = '0;
                        state_next = S_THR;
                    end
                    else if (rd_mag >= max_reg)
                    begin
                        vq_next    = gehc_pkg::V_ONE;
                        state_next = S_THR;
                    end
                    else
                    begin
                        rd_cmd.start  = 1'b1;
                        rd_cmd.is_div = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (rd_stat.done)
                begin
                    vq_next    = gehc_pkg::V_W'(rd_quo);
                    state_next = S_THR;
                end
            end
            S_THR:
            begin
                if (!cd_busy)
                begin
                    col_start  = 1'b1;
                    state_next = S_COLOR;
                end
            end
            S_COLOR:
            begin
                if (col_stat.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    red_next       = col_red;
                    green_next     = col_green;
                    blue_next      = col_blue;
                    edge_next      = col_edge;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            map_reg       <= 1'b0;
            min_reg       <= gehc_pkg::MAG_MAX;
            max_reg       <= '0;
            thr_reg       <= gehc_pkg::THR_RESET;
            vq_reg        <= '0;
            out_valid_reg <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            edge_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            map_reg       <= map_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            thr_reg       <= thr_next;
            vq_reg        <= vq_next;
            out_valid_reg <= out_valid_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            edge_reg      <= edge_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign edge_strength = edge_reg;

    // new transaction only with the root/divide and color units free
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!rd_stat.busy && !col_stat.busy))
        else $error("transaction accepted while a unit is busy");

    // root or divide finishes only while the sequencer waits for it
    a_rd_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        rd_stat.done |-> (state_reg == S_ROOT || state_reg == S_DIV))
        else $error("root/divide completion outside its wait state");

    // color completion only while waiting for it
    a_col_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        col_stat.done |-> (state_reg == S_COLOR))
        else $error("color completion outside its wait state");

    // normalized value never above one
    a_vq_range: assert property (@(posedge clk) disable iff (!rst_n)
        vq_reg <= gehc_pkg::V_ONE)
        else $error("normalized value above one");

    // result appears only from the output state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside output state");

endmodule

// ----- tb/gradient_edge_hsl_colorize_test.sv -----
// self-checking testbench of the two-pass gradient edge colorizer
`timescale 1ns / 1ps
module gradient_edge_hsl_colorize_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 2000;
    localparam longint unsigned SIXTY = 64'd3932160;
    localparam longint unsigned ONE_TWENTY = 64'd7864320;
    localparam longint unsigned MAG_LIMIT = 64'h1FFFF;

    typedef enum logic [1:0] { K_PIXEL, K_THRESHOLD, K_DRAIN } entry_kind_t;

    typedef struct {
        entry_kind_t kind;
        logic [1:0]  op;
        logic [7:0]  gx;
        logic [7:0]  gy;
        logic [15:0] thr;
        bit          calm;
    } entry_t;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] strength;
    } color_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [7:0]  grad_x;
    logic [7:0]  grad_y;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  edge_strength;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    entry_t pending[$];
    color_t colors_due[$];

    // predictor state
    longint unsigned mag_lo;
    longint unsigned mag_hi;
    longint unsigned thr_model;

    int  mismatches;
    int  cycles;
    int  gap;
    int  settle;
    int  out_stall;
    bit  in_taken;
    bit  out_taken;
    bit  calm_in;
    int  item_count;

    gradient_edge_hsl_colorize dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .grad_x(grad_x), .grad_y(grad_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .red(red), .green(green), .blue(blue), .edge_strength(edge_strength),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // integer square root, digit by digit
    function automatic longint unsigned int_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned grad_magnitude(input logic [7:0] gx,
                                                       input logic [7:0] gy);
        longint unsigned m;
        m = int_root((longint'(gx) * gx + longint'(gy) * gy)
                     << (2 * gehc_pkg::MAG_FRAC_BITS));
        return (m > MAG_LIMIT) ? MAG_LIMIT : m;
    endfunction

    // vectoring rotation toward the x axis, angle in degrees Q.16
    function automatic longint grad_angle(input logic [7:0] gx, input logic [7:0] gy);
        longint x;
        longint y;
        longint z;
        longint nx;
        if (gy == 0)
            return 0;
        if (gx == 0)
            return 90 * 65536;
        x = longint'(gx) << 16;
        y = longint'(gy) << 16;
        z = 0;
        for (int i = 0; i < gehc_pkg::CORDIC_STEPS && i < 24; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(gehc_pkg::atan_entry(5'(i)));
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(gehc_pkg::atan_entry(5'(i)));
            end
            x = nx;
        end
        if (z < 0)
            z = 0;
        if (z > 90 * 65536)
            z = 90 * 65536;
        return z;
    endfunction

    function automatic logic [7:0] channel_of(input longint unsigned comp,
                                              input longint unsigned m);
        longint unsigned q;
        q = (64'd255 * (comp + m)) / (SIXTY << 33);
        return q[7:0];
    endfunction

    // expected color of one mapped pixel
    function automatic color_t edge_color(input logic [7:0] gx, input logic [7:0] gy);
        longint unsigned mag, vq, dev, c32, rem, w, c_num, x_num, m_num, hue;
        longint unsigned rc, gc, bc, s;
        color_t res;
        mag = grad_magnitude(gx, gy);
        if (mag_hi <= mag_lo || mag <= mag_lo)
            vq = 0;
        else if (mag >= mag_hi)
            vq = 65536;
        else
            vq = ((mag - mag_lo) << 16) / (mag_hi - mag_lo);
        if (vq <= thr_model)
            vq = 0;
        hue = 64'(180 * 65536) + unsigned'(grad_angle(gx, gy));
        dev = (2 * vq >= 65536) ? 2 * vq - 65536 : 65536 - 2 * vq;
        c32 = (65536 - dev) * vq;
        rem = hue % ONE_TWENTY;
        w = SIXTY - ((rem >= SIXTY) ? rem - SIXTY : SIXTY - rem);
        c_num = 2 * c32 * SIXTY;
        x_num = 2 * c32 * w;
        m_num = ((vq << 17) - c32) * SIXTY;
        rc = 0;
        gc = 0;
        bc = 0;
        if (hue < 60 * 65536)
        begin
            rc = c_num; gc = x_num;
        end
        else if (hue < 120 * 65536)
        begin
            rc = x_num; gc = c_num;
        end
        else if (hue < 180 * 65536)
        begin
            gc = c_num; bc = x_num;
        end
        else if (hue < 240 * 65536)
        begin
            gc = x_num; bc = c_num;
        end
        else if (hue < 300 * 65536)
        begin
            bc = c_num; rc = x_num;
        end
        else
        begin
            bc = x_num; rc = c_num;
        end
        res.r = channel_of(rc, m_num);
        res.g = channel_of(gc, m_num);
        res.b = channel_of(bc, m_num);
        s = (64'd255 * vq) >> 16;
        res.strength = s[7:0];
        return res;
    endfunction

    // update extremes or queue the expected color for one accepted transaction
    task automatic predict_pixel(input logic [1:0] op, input logic [7:0] gx,
                                 input logic [7:0] gy);
        longint unsigned mag;
        if (op == gehc_pkg::OP_CLEAR)
        begin
            mag_lo = MAG_LIMIT;
            mag_hi = 0;
        end
        else if (op == gehc_pkg::OP_MEASURE)
        begin
            mag = grad_magnitude(gx, gy);
            if (mag < mag_lo)
                mag_lo = mag;
            if (mag > mag_hi)
                mag_hi = mag;
        end
        else if (op == gehc_pkg::OP_MAP)
            colors_due.push_back(edge_color(gx, gy));
    endtask

    task automatic add_pixel(input logic [1:0] op, input logic [7:0] gx,
                             input logic [7:0] gy, input bit calm);
        entry_t e;
        e.kind = K_PIXEL;
        e.op = op;
        e.gx = gx;
        e.gy = gy;
        e.thr = '0;
        e.calm = calm;
        pending.push_back(e);
        item_count++;
    endtask

    task automatic add_control(input entry_kind_t kind, input logic [15:0] thr);
        entry_t e;
        e.kind = kind;
        e.op = gehc_pkg::OP_CLEAR;
        e.gx = '0;
        e.gy = '0;
        e.thr = thr;
        e.calm = 1'b0;
        pending.push_back(e);
    endtask

    function automatic logic [7:0] rand_grad();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 3));
            1: return 8'($urandom_range(252, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] rand_threshold();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return gehc_pkg::THR_RESET;
            default: return 16'($urandom_range(0, 40000));
        endcase
    endfunction

    // stimulus
    initial
    begin
        bit calm;
        int n_meas;
        int n_map;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = gehc_pkg::OP_CLEAR;
        grad_x = '0;
        grad_y = '0;
        out_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        mag_lo = MAG_LIMIT;
        mag_hi = 0;
        thr_model = gehc_pkg::THR_RESET;
        mismatches = 0;
        cycles = 0;
        gap = 0;
        settle = 0;
        out_stall = 0;
        item_count = 0;

        // directed: map with no pixel measured, then the usual two passes
        add_pixel(gehc_pkg::OP_MAP, 8'd100, 8'd50, 1'b0);
        add_pixel(OP_UNUSED, 8'd255, 8'd255, 1'b0);
        add_pixel(gehc_pkg::OP_MEASURE, 8'd0, 8'd0, 1'b0);
        add_pixel(gehc_pkg::OP_MEASURE, 8'd255, 8'd255, 1'b0);
        add_pixel(gehc_pkg::OP_MEASURE, 8'd10, 8'd0, 1'b0);
        add_pixel(gehc_pkg::OP_MAP, 8'd0, 8'd0, 1'b0);
        add_pixel(gehc_pkg::OP_MAP, 8'd255, 8'd255, 1'b0);
        add_pixel(gehc_pkg::OP_MAP, 8'd0, 8'd200, 1'b0);
        add_pixel(gehc_pkg::OP_MAP, 8'd200, 8'd0, 1'b0);
        add_pixel(gehc_pkg::OP_MAP, 8'd100, 8'd100, 1'b0);
        add_pixel(gehc_pkg::OP_MAP, 8'd1, 8'd255, 1'b0);
        add_pixel(gehc_pkg::OP_MAP, 8'd255, 8'd1, 1'b0);
        add_control(K_THRESHOLD, 16'd0);
        add_pixel(gehc_pkg::OP_MAP, 8'd20, 8'd3, 1'b0);
        add_pixel(gehc_pkg::OP_MAP, 8'd128, 8'd127, 1'b0);
        add_control(K_THRESHOLD, 16'hFFFF);
        add_pixel(gehc_pkg::OP_MAP, 8'd255, 8'd255, 1'b0);
        add_pixel(gehc_pkg::OP_MAP, 8'd180, 8'd90, 1'b0);
        add_pixel(gehc_pkg::OP_CLEAR, 8'd0, 8'd0, 1'b0);
        add_pixel(gehc_pkg::OP_MEASURE, 8'd7, 8'd9, 1'b0);
        add_pixel(gehc_pkg::OP_MAP, 8'd7, 8'd9, 1'b0);
        add_control(K_THRESHOLD, gehc_pkg::THR_RESET);

        // random phases: mostly clear, measure, map sequences
        while (item_count < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
                add_control(K_THRESHOLD, rand_threshold());
            if ($urandom_range(0, 7) == 0)
                add_control(K_DRAIN, '0);
            if ($urandom_range(0, 5) != 0)
                add_pixel(gehc_pkg::OP_CLEAR, rand_grad(), rand_grad(), calm);
            n_meas = $urandom_range(1, 12);
            n_map = $urandom_range(1, 20);
            for (int i = 0; i < n_meas; i++)
                add_pixel(gehc_pkg::OP_MEASURE, rand_grad(), rand_grad(), calm);
            for (int i = 0; i < n_map; i++)
            begin
                case ($urandom_range(0, 19))
                    0: add_pixel(OP_UNUSED, rand_grad(), rand_grad(), calm);
                    1: add_pixel(gehc_pkg::OP_MEASURE, rand_grad(), rand_grad(), calm);
                    2: add_pixel(gehc_pkg::OP_CLEAR, rand_grad(), rand_grad(), calm);
                    default: add_pixel(gehc_pkg::OP_MAP, rand_grad(), rand_grad(), calm);
                endcase
            end
        end
        add_control(K_DRAIN, '0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || in_valid || colors_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // driver: one input transaction or one threshold write at a time
    always @(negedge clk)
    begin
        entry_t e;
        bit nv;
        bit wen;
        if (rst_n)
        begin
            nv = in_valid && !in_taken;
            wen = 1'b0;
            if (!nv)
            begin
                if (gap > 0)
                    gap--;
                else if (pending.size() != 0)
                begin
                    e = pending[0];
                    if (e.kind == K_PIXEL)
                    begin
                        void'(pending.pop_front());
                        operation <= e.op;
                        grad_x <= e.gx;
                        grad_y <= e.gy;
                        nv = 1'b1;
                        calm_in = e.calm;
                        gap = e.calm ? 0 : $urandom_range(0, 4);
                        settle = 0;
                    end
                    else if (colors_due.size() != 0)
                        settle = 0;
                    else if (settle < SETTLE_CYCLES)
                        settle++;
                    else
                    begin
                        void'(pending.pop_front());
                        settle = 0;
                        if (e.kind == K_THRESHOLD)
                        begin
                            wen = 1'b1;
                            cfg_wr_data <= e.thr;
                            thr_model = e.thr;
                        end
                    end
                end
            end
            in_valid <= nv;
            cfg_wr_en <= wen;
        end
    end

    // result side back-pressure, none during calm phases
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                out_stall = (calm_in || ((cycles / 400) % 3 == 0)) ? 0
                                                                   : $urandom_range(0, 4);
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: predict on accepted input, check accepted results
    always @(posedge clk)
    begin
        color_t exp_c;
        in_taken = in_valid && in_ready;
        out_taken = out_valid && out_ready;
        if (in_taken)
            predict_pixel(operation, grad_x, grad_y);
        if (out_taken)
        begin
            if (colors_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result r=%0d g=%0d b=%0d s=%0d",
                             red, green, blue, edge_strength);
            end
            else
            begin
                exp_c = colors_due.pop_front();
                if (red !== exp_c.r || green !== exp_c.g || blue !== exp_c.b
                    || edge_strength !== exp_c.strength)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 exp_c.r, exp_c.g, exp_c.b, exp_c.strength,
                                 red, green, blue, edge_strength);
                end
            end
        end
    end

endmodule
